// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl modules
// no dependencies; include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/fpt_pkg.sv -----
// shared types and constants for the feature phase table
// no dependencies
package fpt_pkg;

    localparam int MAX_FEATURES = 4096;
    localparam int FID_W        = $clog2(MAX_FEATURES);
    localparam int PHASE_BITS   = 15;
    localparam int CELL_W       = 16;
    localparam int FC_W         = 13;
    localparam int CNT_W        = 13;

    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [FC_W-1:0]  FC_RESET  = 13'd4096;
    localparam logic [FC_W-1:0]  FC_LIMIT  = FC_W'(MAX_FEATURES);
    localparam logic [FID_W-1:0] LAST_ADDR = FID_W'(MAX_FEATURES - 1);

    // request kinds
    localparam logic REQ_CELL = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NEG     = 2'd1,
        ST_RANGE   = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    // one table entry as held in memory
    typedef struct packed {
        logic                  conflict;
        logic                  seen;
        logic [PHASE_BITS-1:0] phase;
    } entry_t;

    // controller to datapath commands
    typedef struct packed {
        logic             launch;
        logic             commit;
        logic             clear_wr;
        logic [FID_W-1:0] clear_addr;
    } fpt_cmd_t;

endpackage

// ----- rtl/feature_phase_table.sv -----
// Feature phase table. After reset the block sweeps its 4096-entry table to
// zero, one entry per cycle, and stalls input during the sweep; configuration
// writes are taken at any time. Each transaction then reads its entry from the
// single-port memory into a register, then computes, writes back and loads the
// result register once the output is free. A new transaction is taken while
// the previous result waits at the output.
module feature_phase_table (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fpt_pkg::FC_W-1:0]          cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              req_type,
    input  logic [fpt_pkg::FID_W-1:0]         feature_id,
    input  logic signed [fpt_pkg::CELL_W-1:0] cell_phase,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [fpt_pkg::PHASE_BITS-1:0]    entry_phase,
    output logic                              entry_seen,
    output logic                              entry_conflict,
    output logic                              new_conflict,
    output logic [fpt_pkg::CNT_W-1:0]         conflict_total,
    output logic [1:0]                        status
);
    import fpt_pkg::*;

    fpt_cmd_t cmd;

    // configuration is always writable
    assign cfg_ready = 1'b1;

    // controller
    fpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // datapath
    fpt_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_data       (cfg_data),
        .req_type       (req_type),
        .feature_id     (feature_id),
        .cell_phase     (cell_phase),
        .entry_phase    (entry_phase),
        .entry_seen     (entry_seen),
        .entry_conflict (entry_conflict),
        .new_conflict   (new_conflict),
        .conflict_total (conflict_total),
        .status         (status)
    );

endmodule

// ----- rtl/fpt_datapath.sv -----
// datapath: table memory, request registers, error flag, conflict counter,
// result registers and the feature count register; uses fpt_pkg
module fpt_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fpt_pkg::fpt_cmd_t                 cmd,
    input  logic                              cfg_we,
    input  logic [fpt_pkg::FC_W-1:0]          cfg_data,
    input  logic                              req_type,
    input  logic [fpt_pkg::FID_W-1:0]         feature_id,
    input  logic signed [fpt_pkg::CELL_W-1:0] cell_phase,
    output logic [fpt_pkg::PHASE_BITS-1:0]    entry_phase,
    output logic                              entry_seen,
    output logic                              entry_conflict,
    output logic                              new_conflict,
    output logic [fpt_pkg::CNT_W-1:0]         conflict_total,
    output logic [1:0]                        status
);
    import fpt_pkg::*;

    entry_t               mem [MAX_FEATURES];
    entry_t               rd_data_reg;
    logic                 req_type_reg;
    logic [FID_W-1:0]     req_fid_reg;
    logic [CELL_W-1:0]    req_phase_reg;
    logic [FC_W-1:0]      feature_count_reg;
    logic                 err_reg;
    logic                 err_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;

    logic [FC_W-1:0]       limit;
    logic                  in_range;
    logic                  is_cell;
    logic                  negative;
    logic                  update;
    logic                  fresh;
    logic [PHASE_BITS-1:0] new_phase;
    entry_t                new_entry;
    entry_t                shown;
    status_t               status_next;

    // feature count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            feature_count_reg <= FC_RESET;
        else if (cfg_we)
            feature_count_reg <= cfg_data;
    end

    // capture request and launch the table read
    always_ff @(posedge clk)
    begin
        if (cmd.launch)
        begin
            req_type_reg  <= req_type;
            req_fid_reg   <= feature_id;
            req_phase_reg <= cell_phase;
            rd_data_reg   <= mem[feature_id];
        end
    end

    // update decision for the captured transaction
    always_comb
    begin
        limit     = (feature_count_reg > FC_LIMIT) ? FC_LIMIT : feature_count_reg;
        in_range  = FC_W'(req_fid_reg) < limit;
        is_cell   = (req_type_reg == REQ_CELL);
        negative  = req_phase_reg[CELL_W-1];
        new_phase = req_phase_reg[PHASE_BITS-1:0];
        update    = in_range && is_cell && !err_reg && (req_fid_reg != '0) && !negative;
        fresh     = update && rd_data_reg.seen && (rd_data_reg.phase != new_phase)
                    && !rd_data_reg.conflict;
        new_entry = rd_data_reg;
        if (update)
        begin
            new_entry.phase    = new_phase;
            new_entry.seen     = 1'b1;
            new_entry.conflict = rd_data_reg.conflict || fresh;
        end
        shown = in_range ? new_entry : '0;

        err_next = err_reg;
        if (in_range && is_cell && !err_reg && (req_fid_reg != '0) && negative)
            err_next = 1'b1;

        cnt_next = cnt_reg;
        if (fresh && (cnt_reg != CNT_MAX))
            cnt_next = cnt_reg + 1'b1;

        if (!in_range)
            status_next = ST_RANGE;
        else if (!is_cell)
            status_next = ST_OK;
        else if (err_reg)
            status_next = ST_IGNORED;
        else if (req_fid_reg == '0)
            status_next = ST_OK;
        else if (negative)
            status_next = ST_NEG;
        else
            status_next = ST_OK;
    end

    // table write: clearing sweep or commit of an update
    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
            mem[cmd.clear_addr] <= '0;
        else if (cmd.commit && update)
            mem[req_fid_reg] <= new_entry;
    end

    // sticky error and conflict counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (cmd.commit)
        begin
            err_reg <= err_next;
            cnt_reg <= cnt_next;
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            entry_phase    <= shown.phase;
            entry_seen     <= shown.seen;
            entry_conflict <= shown.conflict;
            new_conflict   <= fresh;
            conflict_total <= cnt_next;
            status         <= status_next;
        end
    end

endmodule

// ----- rtl/fpt_ctrl.sv -----
// controller: clearing sweep after reset, transaction sequencing and
// output valid; uses fpt_pkg and assert_macros.svh
`include "assert_macros.svh"
module fpt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output fpt_pkg::fpt_cmd_t cmd
);
    import fpt_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    state_t           state_reg;
    logic [FID_W-1:0] clr_addr_reg;
    logic             out_valid_reg;
    logic             out_free;
    logic             accept;
    logic             exec_wait;

    // handshake decode
    always_comb
    begin
        in_stall       = (state_reg != S_IDLE);
        accept         = in_valid && !in_stall;
        out_free       = !out_valid_reg || !out_stall;
        exec_wait      = (state_reg == S_EXEC) && out_valid_reg;
        cmd.launch     = accept;
        cmd.commit     = (state_reg == S_EXEC) && out_free;
        cmd.clear_wr   = (state_reg == S_CLEAR);
        cmd.clear_addr = clr_addr_reg;
    end

    assign out_valid = out_valid_reg;

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == LAST_ADDR)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                        state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    `ASSERT_NEXT(a_accept_exec, clk, rst_n, accept, state_reg == S_EXEC)
    `ASSERT_NEXT(a_commit_valid, clk, rst_n, cmd.commit, out_valid_reg)
    `ASSERT_NEXT(a_blocked_hold, clk, rst_n, exec_wait && out_stall, exec_wait)
    `ASSERT_NEXT(a_clear_runs, clk, rst_n, cmd.clear_wr && (clr_addr_reg != LAST_ADDR), cmd.clear_wr)

endmodule

// ----- test/tb.sv -----
// testbench for feature_phase_table: directed and random transactions with
// bursty sender, patterned receiver stall and a scoreboard that predicts each result
// depends on fpt_pkg and feature_phase_table
module tb;
    import fpt_pkg::*;

    localparam int IDLE_LIMIT   = 12000;
    localparam int HOLD_CYCLES  = 120;
    localparam int REPORT_LIMIT = 10;
    localparam int TAIL_CYCLES  = 4;

    // one result transaction, fields in port order
    typedef struct packed {
        logic [PHASE_BITS-1:0] phase;
        logic                  seen;
        logic                  conflict;
        logic                  fresh;
        logic [CNT_W-1:0]      total;
        status_t               code;
    } table_result_t;

    typedef enum int {FLOW, LIGHT_STALL, HEAVY_STALL} stall_mode_t;

    // predicted table contents and queue of expected results
    class phase_table_scoreboard;
        bit [PHASE_BITS-1:0] phase_mem [MAX_FEATURES];
        bit                  seen_mem [MAX_FEATURES];
        bit                  conflict_mem [MAX_FEATURES];
        bit [CNT_W-1:0]      conflict_count;
        bit                  error_sticky;
        bit [FC_W-1:0]       feature_limit;
        table_result_t       expected_q [$];
        int                  fail_count;

        function new();
            feature_limit = FC_RESET;
        endfunction

        function void set_feature_count(bit [FC_W-1:0] value);
            feature_limit = value;
        endfunction

        function int waiting();
            return expected_q.size();
        endfunction

        // apply one accepted request to the predicted table
        function void note_request(logic kind, logic [FID_W-1:0] fid,
                                   logic signed [CELL_W-1:0] raw);
            table_result_t       r;
            int unsigned         used;
            bit [PHASE_BITS-1:0] p;
            used = (feature_limit > FC_LIMIT) ? MAX_FEATURES : feature_limit;
            r = '0;
            if (fid >= used)
            begin
                r.code = ST_RANGE;
            end
            else
            begin
                if (kind == REQ_CELL)
                begin
                    if (error_sticky)
                    begin
                        r.code = ST_IGNORED;
                    end
                    else if (fid != 0)
                    begin
                        if (raw[CELL_W-1])
                        begin
                            r.code = ST_NEG;
                            error_sticky = 1'b1;
                        end
                        else
                        begin
                            p = raw[PHASE_BITS-1:0];
                            // first differing phase flags the entry
                            if (seen_mem[fid] && phase_mem[fid] != p && !conflict_mem[fid])
                            begin
                                conflict_mem[fid] = 1'b1;
                                r.fresh = 1'b1;
                                if (conflict_count != CNT_MAX)
                                    conflict_count++;
                            end
                            phase_mem[fid] = p;
                            seen_mem[fid] = 1'b1;
                        end
                    end
                end
                r.phase    = phase_mem[fid];
                r.seen     = seen_mem[fid];
                r.conflict = conflict_mem[fid];
            end
            r.total = conflict_count;
            expected_q = {expected_q, r};
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_entry(table_result_t got);
            table_result_t want;
            if (expected_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result transaction at %0t", $realtime);
                return;
            end
            want = expected_q.pop_front();
            if (got.phase !== want.phase || got.seen !== want.seen ||
                got.conflict !== want.conflict || got.fresh !== want.fresh ||
                got.total !== want.total || got.code !== want.code)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                begin
                    $display("mismatch at %0t", $realtime);
                    $display("  expected phase %0d seen %0d conflict %0d new %0d total %0d code %0d",
                             want.phase, want.seen, want.conflict, want.fresh,
                             want.total, want.code);
                    $display("  got      phase %0d seen %0d conflict %0d new %0d total %0d code %0d",
                             got.phase, got.seen, got.conflict, got.fresh,
                             got.total, got.code);
                end
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [FC_W-1:0]          cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic                     req_type;
    logic [FID_W-1:0]         feature_id;
    logic signed [CELL_W-1:0] cell_phase;
    logic                     out_valid;
    logic                     out_stall;
    logic [PHASE_BITS-1:0]    entry_phase;
    logic                     entry_seen;
    logic                     entry_conflict;
    logic                     new_conflict;
    logic [CNT_W-1:0]         conflict_total;
    logic [1:0]               status;

    phase_table_scoreboard sb;
    int                    active_limit;
    bit                    hold_request;
    int                    quiet_cycles;

    feature_phase_table dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .feature_id     (feature_id),
        .cell_phase     (cell_phase),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .entry_phase    (entry_phase),
        .entry_seen     (entry_seen),
        .entry_conflict (entry_conflict),
        .new_conflict   (new_conflict),
        .conflict_total (conflict_total),
        .status         (status)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watch both channels, predict on input and check on output
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (in_valid && !in_stall)
                sb.note_request(req_type, feature_id, cell_phase);
            if (out_valid && !out_stall)
                sb.check_entry(table_result_t'({entry_phase, entry_seen, entry_conflict,
                                                new_conflict, conflict_total, status}));
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial
    begin
        int          seg_left;
        stall_mode_t mode;
        out_stall <= 1'b0;
        seg_left = 0;
        mode = FLOW;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode = stall_mode_t'($urandom_range(0, 2));
                    seg_left = $urandom_range(4, 60);
                end
                seg_left--;
                case (mode)
                    FLOW:        out_stall <= 1'b0;
                    LIGHT_STALL: out_stall <= ($urandom_range(0, 3) == 0);
                    default:     out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // write feature_count through the config channel
    task write_feature_count(input logic [FC_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_feature_count(value);
        active_limit = (value > FC_LIMIT) ? MAX_FEATURES : value;
    endtask

    // offer one request transaction and wait until it is taken
    task send_item(input logic kind, input logic [FID_W-1:0] fid,
                   input logic signed [CELL_W-1:0] raw);
        in_valid   <= 1'b1;
        req_type   <= kind;
        feature_id <= fid;
        cell_phase <= raw;
        do @(posedge clk); while (in_stall);
    endtask

    // wait until every expected result has come back
    task drain();
        do @(posedge clk); while (sb.waiting() != 0);
    endtask

    // random requests, mostly cells and reads on a pool of features
    task send_mix(input int count, input int lo, input int hi, input bit bursty,
                  input bit error_ok);
        int                       sent;
        int                       burst;
        int                       gap;
        int                       pick;
        int                       k;
        logic                     kind;
        logic [FID_W-1:0]         fid;
        logic signed [CELL_W-1:0] raw;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 12);
            for (k = 0; k < burst && sent < count; k++)
            begin
                pick = $urandom_range(0, 99);
                fid  = FID_W'($urandom_range(lo, hi));
                kind = REQ_CELL;
                // phases mostly from a small set so repeats and conflicts both happen
                case ($urandom_range(0, 4))
                    0:       raw = 16'sd0;
                    1:       raw = 16'sd1;
                    2:       raw = 16'sh7fff;
                    3:       raw = CELL_W'($urandom_range(2, 4));
                    default: raw = CELL_W'($urandom_range(0, 16'h7fff));
                endcase
                if (pick >= 55 && pick < 80)
                begin
                    kind = REQ_READ;
                    raw = CELL_W'($urandom);
                end
                else if (pick >= 80 && pick < 88)
                begin
                    fid = '0;
                    raw = CELL_W'($urandom);
                end
                else if (pick >= 88)
                begin
                    kind = 1'($urandom_range(0, 1));
                    fid = FID_W'($urandom);
                    raw = CELL_W'($urandom);
                end
                // keep the error latch clear until the error phase
                if (!error_ok && kind == REQ_CELL && fid != 0 && fid < active_limit)
                    raw[CELL_W-1] = 1'b0;
                send_item(kind, fid, raw);
                sent++;
            end
            gap = bursty ? $urandom_range(0, 8) : 0;
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
    endtask

    // main sequence
    initial
    begin
        sb = new();
        hold_request = 1'b0;
        active_limit = MAX_FEATURES;
        rst_n      <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        req_type   <= REQ_CELL;
        feature_id <= '0;
        cell_phase <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: full table, conflicts, feature zero, extremes
        write_feature_count(FC_RESET);
        send_item(REQ_READ, 12'd5, 16'sd0);
        send_item(REQ_CELL, 12'd1, 16'sd0);
        send_item(REQ_CELL, 12'd1, 16'sd0);
        send_item(REQ_CELL, 12'd1, 16'sh7fff);
        send_item(REQ_CELL, 12'd1, 16'sd3);
        send_item(REQ_READ, 12'd1, 16'sh7fff);
        send_item(REQ_CELL, LAST_ADDR, 16'sh7fff);
        send_item(REQ_READ, LAST_ADDR, -16'sd1);
        send_item(REQ_CELL, 12'd0, 16'sh8000);
        send_item(REQ_CELL, 12'd0, 16'sd5);
        send_item(REQ_READ, 12'd0, 16'sh8000);
        send_item(REQ_CELL, 12'd2, 16'sd100);
        send_item(REQ_CELL, 12'd2, 16'sd100);
        send_item(REQ_READ, 12'd2, 16'sd0);
        in_valid <= 1'b0;
        drain();

        // single entry in use
        write_feature_count(13'd1);
        send_item(REQ_CELL, 12'd1, 16'sd5);
        send_item(REQ_READ, 12'd0, 16'sd0);
        send_item(REQ_READ, 12'd1, 16'sd0);
        send_item(REQ_CELL, 12'd0, -16'sd7);
        send_item(REQ_CELL, LAST_ADDR, 16'sh8000);
        in_valid <= 1'b0;
        drain();

        // nothing in range
        write_feature_count(13'd0);
        send_item(REQ_READ, 12'd0, 16'sd0);
        send_item(REQ_CELL, 12'd0, 16'sd9);
        in_valid <= 1'b0;
        drain();

        // oversized count acts as the full table
        write_feature_count(CNT_MAX);
        send_item(REQ_CELL, LAST_ADDR, 16'sd7);
        send_item(REQ_READ, LAST_ADDR, 16'sd0);
        in_valid <= 1'b0;
        drain();

        // random phases over several table sizes
        write_feature_count(FC_RESET);
        send_mix(70, 1, 40, 1'b1, 1'b0);
        drain();
        write_feature_count(13'd64);
        send_mix(70, 1, 80, 1'b1, 1'b0);
        drain();
        write_feature_count(13'd200);
        send_mix(70, 100, 260, 1'b1, 1'b0);
        drain();
        write_feature_count(13'd3000);
        send_mix(70, 2900, 3100, 1'b1, 1'b0);
        drain();
        write_feature_count(13'd4097);
        send_mix(70, 4000, 4095, 1'b1, 1'b0);
        drain();

        // receiver holds off while the sender keeps offering
        write_feature_count(FC_RESET);
        hold_request = 1'b1;
        send_mix(50, 1, 30, 1'b0, 1'b0);
        wait (hold_request == 1'b0);
        drain();

        // negative phase latches the error; later in-range cells are ignored
        write_feature_count(13'd100);
        send_item(REQ_CELL, 12'd50, 16'sd7);
        send_item(REQ_CELL, 12'd50, 16'sh8001);
        send_item(REQ_CELL, 12'd60, 16'sd5);
        send_item(REQ_CELL, 12'd0, 16'sd0);
        send_item(REQ_CELL, 12'd200, 16'sd1);
        send_item(REQ_READ, 12'd50, 16'sd0);
        send_item(REQ_READ, 12'd300, 16'sd0);
        in_valid <= 1'b0;
        drain();
        write_feature_count(FC_RESET);
        send_mix(25, 1, 60, 1'b1, 1'b1);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.fail_count == 0 && sb.waiting() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/fpt_pkg.sv
rtl/fpt_datapath.sv
rtl/fpt_ctrl.sv
rtl/feature_phase_table.sv
test/tb.sv
